// File: hw/rtl/bes_pkg.sv
// Shared types and constants of the boxcar envelope slicer.
`default_nettype none

package bes_pkg;

  // Field widths.
  localparam int unsigned DATA_W = 16;
  localparam int unsigned THR_W  = 15;
  localparam int unsigned RUN_W  = 32;

  // Configuration port geometry and register map.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_SLICE_THRESHOLD = '0;

  // Register reset value and counter limit.
  localparam logic [THR_W-1:0] THR_RESET = 15'd6553;
  localparam logic [RUN_W-1:0] RUN_MAX   = '1;

  // Largest positive sample, the start value of the minimum search.
  localparam logic signed [DATA_W-1:0] DATA_MAX = 16'sh7FFF;

  // Status of the queue between the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One result item.
  typedef struct packed {
    logic signed [DATA_W-1:0] envelope;
    logic                     level;
    logic                     edge_res;
    logic [RUN_W-1:0]         run_ticks;
  } bes_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bes_front.sv
// Front part: sample delay line, running boxcar sum and decimation.
`default_nettype none

module bes_front #(
  parameter int unsigned AVG_LEN = 36,
  parameter int unsigned SUM_W   = 22
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  input  wire logic signed [bes_pkg::DATA_W-1:0] sample_i,
  input  wire bes_pkg::q_status_t               q_stat_i,
  output logic                                  q_push_o,
  output logic signed [SUM_W-1:0]               q_data_o
);
  import bes_pkg::*;

  localparam int unsigned POS_W = $clog2(AVG_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_LEN - 1);

  logic signed [DATA_W-1:0] line_mem [AVG_LEN];
  logic signed [DATA_W-1:0] old_q;
  logic signed [DATA_W-1:0] old_val;
  logic [POS_W-1:0]         pos_q, pos_d, pos_next, rd_addr;
  logic                     first_q, first_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic                     accept;

  // A sample transfer happens whenever push is high and the queue has room.
  assign accept   = push_i && !q_stat_i.full;
  assign pos_next = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;

  // The read port always fetches the entry that the next sample replaces.
  assign rd_addr = accept ? pos_next : pos_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[pos_q] <= sample_i;
    end
    old_q <= line_mem[rd_addr];
  end

  // Entries not yet written on the first pass count as zero.
  assign old_val = first_q ? '0 : old_q;
  assign sum_d   = accept ? sum_q - SUM_W'(old_val) + SUM_W'(sample_i) : sum_q;
  assign pos_d   = accept ? pos_next : pos_q;
  assign first_d = (accept && (pos_q == POS_LAST)) ? 1'b0 : first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= 1'b1;
      sum_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      first_q <= first_d;
      sum_q   <= sum_d;
    end
  end

  // Every AVG_LEN-th sample hands the completed sum to the back part.
  assign q_push_o = accept && (pos_q == POS_LAST);
  assign q_data_o = sum_d;

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_stat_i.full)
    else $error("sum pushed into a full queue");

  a_first_pass_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |=> !first_q)
    else $error("first pass still marked after a full window");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/bes_fifo.sv
// Short queue of window sums between the front and back parts.
`default_nettype none

module bes_fifo #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [WIDTH-1:0]   data_i,
  input  wire logic               pop_i,
  output logic [WIDTH-1:0]        data_o,
  output bes_pkg::q_status_t      stat_o
);
  import bes_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = slot_q[rd_ptr_q];

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bes_back.sv
// Back part: average, sliding-minimum baseline, slicer and result register.
`default_nettype none

module bes_back #(
  parameter int unsigned AVG_LEN    = 36,
  parameter int unsigned MIN_WINDOW = 32,
  parameter int unsigned SUM_W      = 22
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic signed [SUM_W-1:0]     q_data_i,
  input  wire bes_pkg::q_status_t          q_stat_i,
  output logic                             q_pop_o,
  input  wire logic [bes_pkg::THR_W-1:0]   threshold_i,
  input  wire logic                        pop_i,
  output logic                             res_valid_o,
  output bes_pkg::bes_result_t             res_o
);
  import bes_pkg::*;

  // Division by AVG_LEN as a multiplication by a rounded-up reciprocal,
  // exact for every magnitude that fits in SUM_W bits.
  localparam int unsigned L_W     = $clog2(AVG_LEN);
  localparam int unsigned SH      = SUM_W + L_W;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SH) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN));

  localparam int unsigned IDX_W = $clog2(MIN_WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MIN_WINDOW - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_SCAN,
    ST_DRAIN,
    ST_SLICE
  } state_e;

  state_e                   state_q;
  logic [PROD_W-1:0]        prod_q;
  logic                     neg_q;
  logic [SUM_W-1:0]         mag;
  logic [DATA_W-1:0]        quo;
  logic signed [DATA_W-1:0] avg_d, avg_q;
  logic signed [DATA_W-1:0] ring_mem [MIN_WINDOW];
  logic signed [DATA_W-1:0] ring_rd_q;
  logic [IDX_W-1:0]         wr_pos_q, scan_idx_q;
  logic                     wrapped_q;
  logic                     cmp_q, ok_q;
  logic signed [DATA_W-1:0] cand, min_q;
  logic signed [DATA_W-1:0] env;
  logic                     level, edge_now, prev_level_q;
  logic [RUN_W-1:0]         run_cnt_q;
  logic                     take;
  logic                     res_valid_q;
  bes_result_t              res_q;

  // Magnitude of the queued sum, multiplied on the transfer out of the queue.
  assign q_pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign mag     = q_data_i[SUM_W-1] ? SUM_W'(-q_data_i) : SUM_W'(q_data_i);

  // Quotient truncated toward zero, sign restored afterwards.
  assign quo   = prod_q[SH +: DATA_W];
  assign avg_d = neg_q ? -$signed(quo) : $signed(quo);

  // Ring of averages: written once per tick, read one entry a cycle by the scan.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_AVG) begin
      ring_mem[wr_pos_q] <= avg_d;
    end
    ring_rd_q <= ring_mem[scan_idx_q];
  end

  // Entries never written since reset count as zero.
  assign cand = ok_q ? ring_rd_q : '0;

  // Slicing of the baseline-removed envelope.
  assign env      = avg_q - min_q;
  assign level    = $signed({env[DATA_W-1], env}) > $signed({2'b00, threshold_i});
  assign edge_now = (level != prev_level_q);
  assign take     = (state_q == ST_SLICE) && (!res_valid_q || pop_i);

  // Sequencer, scan pipeline, run counter and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wr_pos_q     <= '0;
      wrapped_q    <= 1'b0;
      scan_idx_q   <= '0;
      cmp_q        <= 1'b0;
      ok_q         <= 1'b0;
      prev_level_q <= 1'b0;
      run_cnt_q    <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      cmp_q <= (state_q == ST_SCAN);
      ok_q  <= wrapped_q || (scan_idx_q < wr_pos_q);
      if (cmp_q && (cand < min_q)) begin
        min_q <= cand;
      end
      if (pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            prod_q  <= mag * RECIP;
            neg_q   <= q_data_i[SUM_W-1];
            state_q <= ST_AVG;
          end
        end
        ST_AVG: begin
          avg_q      <= avg_d;
          min_q      <= DATA_MAX;
          scan_idx_q <= '0;
          if (wr_pos_q == IDX_LAST) begin
            wr_pos_q  <= '0;
            wrapped_q <= 1'b1;
          end else begin
            wr_pos_q <= wr_pos_q + 1'b1;
          end
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_idx_q == IDX_LAST) begin
            state_q <= ST_DRAIN;
          end else begin
            scan_idx_q <= scan_idx_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_SLICE;
        end
        ST_SLICE: begin
          if (take) begin
            res_q.envelope  <= env;
            res_q.level     <= level;
            res_q.edge_res  <= edge_now;
            res_q.run_ticks <= edge_now ? run_cnt_q : '0;
            res_valid_q     <= 1'b1;
            prev_level_q    <= level;
            if (edge_now) begin
              run_cnt_q <= RUN_W'(1);
            end else if (run_cnt_q != RUN_MAX) begin
              run_cnt_q <= run_cnt_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_stat_i.empty)
    else $error("sum taken from an empty queue");

  a_run_only_on_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.edge_res) |-> (res_q.run_ticks == '0))
    else $error("run length reported without a level change");

  a_slice_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (res_valid_q && (state_q == ST_IDLE)))
    else $error("sliced result not held in the result register");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/boxcar_envelope_slicer.sv
// Top level of the boxcar envelope slicer: configuration register and wiring.
//
// Samples enter through a queue-style port: a transfer happens at a rising
// edge with push high and full low. The front part takes one sample every cycle
// while full is low, keeps a running sum over the last AVG_LEN samples and, on
// every AVG_LEN-th sample, passes the sum through a two-entry queue to the back
// part. The back part divides by AVG_LEN, writes the average into a MIN_WINDOW
// ring and searches the ring for its minimum one entry a cycle; samples flow at
// one a cycle as long as the back part ends each tick before the next window is
// complete, and full rises otherwise. A result appears on the result ports after
// the average, scan, drain and slice states and stays while empty is low; it is
// taken at an edge with pop high. While the receiver stalls, the back part
// finishes the next tick and waits, the queue fills and full is raised. Reset
// clears the running sum, the positions, the run counter and the level, sets
// slice_threshold to 6553 and treats the delay line and the ring as zero until
// written. The user writes slice_threshold over the APB-style port at address 0
// only while no sample is in flight; the block itself does not enforce this.
`default_nettype none

module boxcar_envelope_slicer #(
  parameter int unsigned AVG_LEN    = 36,
  parameter int unsigned MIN_WINDOW = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [bes_pkg::DATA_W-1:0] sample_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic signed [bes_pkg::DATA_W-1:0]      envelope_o,
  output logic                                   level_o,
  output logic                                   edge_res_o,
  output logic [bes_pkg::RUN_W-1:0]              run_ticks_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bes_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [bes_pkg::PDATA_W-1:0]       pwdata,
  output logic [bes_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready
);
  import bes_pkg::*;

  localparam int unsigned SUM_W = DATA_W + $clog2(AVG_LEN);

  logic [THR_W-1:0]        threshold_q;
  logic                    reg_hit;
  logic                    q_push, q_pop;
  logic signed [SUM_W-1:0] q_wdata, q_rdata;
  q_status_t               q_stat;
  logic                    res_valid;
  bes_result_t             res;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_SLICE_THRESHOLD);
  assign prdata  = reg_hit ? PDATA_W'(threshold_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      threshold_q <= pwdata[THR_W-1:0];
    end
  end

  // Front part.
  bes_front #(
    .AVG_LEN (AVG_LEN),
    .SUM_W   (SUM_W)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (sample_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // Queue of window sums.
  bes_fifo #(
    .WIDTH (SUM_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  // Back part.
  bes_back #(
    .AVG_LEN    (AVG_LEN),
    .MIN_WINDOW (MIN_WINDOW),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_rdata),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .threshold_i (threshold_q),
    .pop_i       (pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Channel status and result fields.
  assign full        = q_stat.full;
  assign empty       = !res_valid;
  assign envelope_o  = res.envelope;
  assign level_o     = res.level;
  assign edge_res_o  = res.edge_res;
  assign run_ticks_o = res.run_ticks;

endmodule

`default_nettype wire
